>>> hdl/running_pairwise_abs_difference_sum_top_assert.svh
// Assertion macros for the pairwise absolute difference sum block.
`ifndef RUNNING_PAIRWISE_ABS_DIFFERENCE_SUM_TOP_ASSERT_SVH
`define RUNNING_PAIRWISE_ABS_DIFFERENCE_SUM_TOP_ASSERT_SVH

// same-cycle implication
`define RPADS_CHK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RPADS_CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/rpads_pkg.sv
// Package: widths and defaults shared by the pairwise difference sum block.
`timescale 1ns / 1ps

package rpads_pkg;

	localparam int SAMPLE_W        = 32;
	localparam int PAIR_SUM_W      = 51;
	localparam int COUNT_W         = 11;
	localparam int MAX_SAMPLES_DEF = 1024;

endpackage

>>> hdl/rpads_cell.sv
// One chain cell: holds one stored sample and adds its distance to passing samples.
`timescale 1ns / 1ps

module rpads_cell #(
	parameter int INDEX       = 0,
	parameter int MAX_SAMPLES = rpads_pkg::MAX_SAMPLES_DEF,
	parameter int POS_W       = $clog2(MAX_SAMPLES + 1),
	parameter int SUM_W       = rpads_pkg::SAMPLE_W + $clog2(MAX_SAMPLES)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic [rpads_pkg::SAMPLE_W-1:0]    in_x,
	input  logic [POS_W-1:0]                  in_pos,
	input  logic [SUM_W-1:0]                  in_sum,
	output logic                              out_valid,
	output logic [rpads_pkg::SAMPLE_W-1:0]    out_x,
	output logic [POS_W-1:0]                  out_pos,
	output logic [SUM_W-1:0]                  out_sum
);
	import rpads_pkg::*;

	logic                    valid_q;
	logic [SAMPLE_W-1:0]     x_q;
	logic [POS_W-1:0]        pos_q;
	logic [SUM_W-1:0]        sum_q;
	logic [SAMPLE_W-1:0]     stored_q;

	logic signed [SAMPLE_W:0] ext_s;
	logic signed [SAMPLE_W:0] ext_x;
	logic signed [SAMPLE_W:0] d_sx;
	logic signed [SAMPLE_W:0] d_xs;
	logic [SAMPLE_W-1:0]      diff_abs;
	logic                     use_cell;
	logic                     hit;

	assign ext_s    = $signed({stored_q[SAMPLE_W-1], stored_q});
	assign ext_x    = $signed({in_x[SAMPLE_W-1], in_x});
	assign d_sx     = ext_s - ext_x;
	assign d_xs     = ext_x - ext_s;
	assign diff_abs = (ext_s >= ext_x) ? d_sx[SAMPLE_W-1:0] : d_xs[SAMPLE_W-1:0];
	// earlier samples of the series live in cells below the sample's position
	assign use_cell = in_valid && (in_pos > POS_W'(INDEX));
	assign hit      = in_valid && (in_pos == POS_W'(INDEX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q   <= in_x;
			pos_q <= in_pos;
			sum_q <= use_cell ? (in_sum + SUM_W'(diff_abs)) : in_sum;
			if (hit) begin
				stored_q <= in_x;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_x     = x_q;
	assign out_pos   = pos_q;
	assign out_sum   = sum_q;

endmodule

>>> hdl/running_pairwise_abs_difference_sum_top.sv
// Each sample passes through every cell of the chain and then the output register before its result is offered.
// Throughput: one sample per cycle while the output is not stalled; each sample moves one cell of the chain per cycle.
// A result stalled at the output holds the whole chain until it is taken.
// Reset clears the series length, running total and all valid flags;
// stored samples are not cleared and are only read once written in the series.
`timescale 1ns / 1ps

module running_pairwise_abs_difference_sum_top #(
	parameter int MAX_SAMPLES = rpads_pkg::MAX_SAMPLES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 sample_valid,
	output logic                                 sample_stall,
	input  logic signed [rpads_pkg::SAMPLE_W-1:0] sample,
	input  logic                                 start_series,
	output logic                                 result_valid,
	input  logic                                 result_stall,
	output logic [rpads_pkg::PAIR_SUM_W-1:0]     pair_sum,
	output logic [rpads_pkg::COUNT_W-1:0]        sample_count,
	output logic                                 overflow
);
	import rpads_pkg::*;

	localparam int POS_W = $clog2(MAX_SAMPLES + 1);
	localparam int SUM_W = SAMPLE_W + $clog2(MAX_SAMPLES);
	localparam logic [POS_W-1:0] POS_FULL = POS_W'(MAX_SAMPLES);

	logic                 advance;
	logic [POS_W-1:0]     cnt_q;
	logic [POS_W-1:0]     in_pos;

	logic                 tok_valid [0:MAX_SAMPLES];
	logic [SAMPLE_W-1:0]  tok_x     [0:MAX_SAMPLES];
	logic [POS_W-1:0]     tok_pos   [0:MAX_SAMPLES];
	logic [SUM_W-1:0]     tok_sum   [0:MAX_SAMPLES];

	logic [PAIR_SUM_W-1:0] total_q;
	logic                  res_valid_q;
	logic [PAIR_SUM_W-1:0] pair_sum_q;
	logic [COUNT_W-1:0]    count_q;
	logic                  overflow_q;

	logic [PAIR_SUM_W:0]   total_add;
	logic [PAIR_SUM_W-1:0] total_sat;
	logic [POS_W:0]        cnt_next;
	logic [POS_W-1:0]      end_pos;

	assign advance      = !(res_valid_q && result_stall);
	assign sample_stall = !advance;

	assign in_pos = start_series ? '0 : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (sample_valid && advance) begin
			if (in_pos != POS_FULL) begin
				cnt_q <= in_pos + POS_W'(1);
			end else begin
				cnt_q <= in_pos;
			end
		end
	end

	assign tok_valid[0] = sample_valid;
	assign tok_x[0]     = sample;
	assign tok_pos[0]   = in_pos;
	assign tok_sum[0]   = '0;

	for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_chain
		rpads_cell #(
			.INDEX       (i),
			.MAX_SAMPLES (MAX_SAMPLES),
			.POS_W       (POS_W),
			.SUM_W       (SUM_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (advance),
			.in_valid  (tok_valid[i]),
			.in_x      (tok_x[i]),
			.in_pos    (tok_pos[i]),
			.in_sum    (tok_sum[i]),
			.out_valid (tok_valid[i+1]),
			.out_x     (tok_x[i+1]),
			.out_pos   (tok_pos[i+1]),
			.out_sum   (tok_sum[i+1])
		);
	end

	assign end_pos   = tok_pos[MAX_SAMPLES];
	assign total_add = {1'b0, total_q} + (PAIR_SUM_W + 1)'(tok_sum[MAX_SAMPLES]);
	assign total_sat = total_add[PAIR_SUM_W] ? '1 : total_add[PAIR_SUM_W-1:0];
	assign cnt_next  = {1'b0, end_pos} + (POS_W + 1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b0;
			if (tok_valid[MAX_SAMPLES]) begin
				if (end_pos == '0) begin
					total_q <= '0;
				end else if (end_pos == POS_FULL) begin
					res_valid_q <= 1'b1;
				end else begin
					total_q     <= total_sat;
					res_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && tok_valid[MAX_SAMPLES]) begin
			if (end_pos == POS_FULL) begin
				pair_sum_q <= total_q;
				count_q    <= COUNT_W'(end_pos);
				overflow_q <= 1'b1;
			end else begin
				pair_sum_q <= total_sat;
				count_q    <= COUNT_W'(cnt_next);
				overflow_q <= 1'b0;
			end
		end
	end

	assign result_valid = res_valid_q;
	assign pair_sum     = pair_sum_q;
	assign sample_count = count_q;
	assign overflow     = overflow_q;

endmodule

>>> hdl/rpads_checker.sv
// Port-level checker for the pairwise difference sum block, bound to the top level.
`timescale 1ns / 1ps
`include "running_pairwise_abs_difference_sum_top_assert.svh"

module rpads_checker #(
	parameter int MAX_SAMPLES = rpads_pkg::MAX_SAMPLES_DEF
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  sample_valid,
	input logic                                  sample_stall,
	input logic                                  result_valid,
	input logic                                  result_stall,
	input logic [rpads_pkg::PAIR_SUM_W-1:0]      pair_sum,
	input logic [rpads_pkg::COUNT_W-1:0]         sample_count,
	input logic                                  overflow
);
	import rpads_pkg::*;

	localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(MAX_SAMPLES);

	logic in_xfer;
	assign in_xfer = sample_valid && !sample_stall;

	// input side is held exactly while a result waits
	`RPADS_CHK_NOW(a_stall_link, 1'b1, sample_stall == (result_valid && result_stall), "input stall does not follow output hold")

	// a dropped sample reports a full store
	`RPADS_CHK_NOW(a_full_count, result_valid && overflow, sample_count == FULL_COUNT, "overflow result with count other than store depth")

	// a result waiting on stall keeps its total
	`RPADS_CHK_NEXT(a_hold_sum, result_valid && result_stall, result_valid && $stable(pair_sum), "stalled result changed")

	// no input transfer while the output holds
	`RPADS_CHK_NOW(a_no_xfer_hold, result_valid && result_stall, !in_xfer, "input transfer during output hold")

endmodule

bind running_pairwise_abs_difference_sum_top rpads_checker #(
	.MAX_SAMPLES (MAX_SAMPLES)
) u_rpads_checker (.*);
